### hw/rtl/tcfr_pkg.sv
// Package for the telemetry command frame receiver: frame constants, parser phases,
// result kinds and the command record passed from the parser to the result sequencer.
// No dependencies.
package tcfr_pkg;

   localparam logic [7:0] HDR1_BYTE    = 8'hAA;
   localparam logic [7:0] HDR2_BYTE    = 8'hAF;
   localparam logic [7:0] FUNC_LIMIT   = 8'hF1;
   localparam logic [7:0] ACK_ID       = 8'hEF;
   localparam logic [7:0] ACK_LEN_BYTE = 8'h02;
   localparam logic [7:0] FN_READBACK  = 8'h02;
   localparam logic [7:0] READBACK_ARG = 8'h01;
   localparam logic [7:0] FN_RATE      = 8'h10;
   localparam logic [7:0] FN_ANGLE     = 8'h11;
   localparam logic [7:0] FN_ACK_LAST  = 8'h15;

   localparam int GAIN_COUNT  = 9;
   localparam int GAIN_BYTES  = 2 * GAIN_COUNT;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] ACK_FIRST_STEP = 4'd9;
   localparam logic [3:0] LAST_STEP      = 4'd15;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR2,
      PH_FUNC,
      PH_LEN,
      PH_DATA,
      PH_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ACK      = 2'd0,
      KIND_GAIN     = 2'd1,
      KIND_READBACK = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      CMD_READBACK,
      CMD_GAINS,
      CMD_ACK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      logic [7:0]                   fn;
      logic [7:0]                   sum;
      logic [GAIN_COUNT-1:0][15:0]  gains;
   } cmd_type;

   function automatic logic [7:0] ack_check(input logic [7:0] fn, input logic [7:0] sum);
      logic [7:0] acc;
      acc = HDR1_BYTE + HDR1_BYTE;
      acc = acc + ACK_ID;
      acc = acc + ACK_LEN_BYTE;
      acc = acc + fn;
      acc = acc + sum;
      return acc;
   endfunction

endpackage

### hw/rtl/tcfr_if.sv
// Valid/ready channel interfaces for received bytes and for result beats.
// Depends on tcfr_pkg.
interface tcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcfr_rsp_if import tcfr_pkg::*; ();
   logic               valid;
   logic               ready;
   rsp_kind_type       kind;
   logic [7:0]         ack_byte;
   logic               gain_set;
   logic [3:0]         gain_index;
   logic signed [15:0] gain_value;
   logic               last;

   modport source (output valid, output kind, output ack_byte, output gain_set,
                   output gain_index, output gain_value, output last, input ready);
   modport sink   (input valid, input kind, input ack_byte, input gain_set,
                   input gain_index, input gain_value, input last, output ready);
endinterface

### hw/rtl/tcfr_front.sv
// Frame parser: tracks header, function, length, payload and checksum bytes,
// keeps the payload store and issues one command per good frame that has results.
// Depends on tcfr_pkg.
module tcfr_front import tcfr_pkg::*; #(
   parameter int MAX_LENGTH   = 49,
   parameter int KEPT_PAYLOAD = 18
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   output logic       push,
   output cmd_type    push_cmd
);

   phase_type  phase_ff, phase_in;
   logic [7:0] fn_ff, fn_in;
   logic [5:0] left_ff, left_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] store_ff [KEPT_PAYLOAD];
   logic [7:0] store_in [KEPT_PAYLOAD];

   logic is_readback, is_gains, is_ack, sum_good;

   always_comb begin
      is_readback = (fn_ff == FN_READBACK) && (store_ff[0] == READBACK_ARG);
      is_gains    = (fn_ff == FN_RATE) || (fn_ff == FN_ANGLE);
      is_ack      = (fn_ff >= FN_RATE) && (fn_ff <= FN_ACK_LAST);
      sum_good    = (rx_byte == sum_ff);

      push_cmd.fn  = fn_ff;
      push_cmd.sum = sum_ff;
      if (is_readback) begin
         push_cmd.kind = CMD_READBACK;
      end else if (is_gains) begin
         push_cmd.kind = CMD_GAINS;
      end else begin
         push_cmd.kind = CMD_ACK;
      end
      for (int k = 0; k < GAIN_COUNT; k++) begin
         push_cmd.gains[k] = {store_ff[2*k], store_ff[2*k+1]};
      end

      push = byte_accept && (phase_ff == PH_CHECK) && sum_good
             && (is_readback || is_ack);
   end

   always_comb begin
      phase_in = phase_ff;
      fn_in    = fn_ff;
      left_in  = left_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      store_in = store_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == HDR1_BYTE) begin
                  phase_in = PH_HDR2;
                  sum_in   = rx_byte;
               end
            end
            PH_HDR2: begin
               if (rx_byte == HDR2_BYTE) begin
                  phase_in = PH_FUNC;
                  sum_in   = sum_ff + rx_byte;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_FUNC: begin
               if (rx_byte < FUNC_LIMIT) begin
                  phase_in = PH_LEN;
                  fn_in    = rx_byte;
                  sum_in   = sum_ff + rx_byte;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_LEN: begin
               if (rx_byte <= 8'(MAX_LENGTH)) begin
                  phase_in = PH_DATA;
                  left_in  = rx_byte[5:0];
                  count_in = '0;
                  sum_in   = sum_ff + rx_byte;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               if (left_ff != '0) begin
                  for (int i = 0; i < KEPT_PAYLOAD; i++) begin
                     if (count_ff == 6'(i)) begin
                        store_in[i] = rx_byte;
                     end
                  end
                  count_in = count_ff + 6'd1;
                  left_in  = left_ff - 6'd1;
                  sum_in   = sum_ff + rx_byte;
                  if (left_ff == 6'd1) begin
                     phase_in = PH_CHECK;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fn_ff    <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < KEPT_PAYLOAD; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         fn_ff    <= fn_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         store_ff <= store_in;
      end
   end

endmodule

### hw/rtl/tcfr_queue.sv
// Short command queue between the frame parser and the result sequencer.
// Depends on tcfr_pkg.
module tcfr_queue import tcfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]      count_ff, count_in;

   always_comb begin
      full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      pop_cmd   = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/tcfr_back.sv
// Result sequencer: expands one command into readback, gain and acknowledge beats
// and drives them through a registered output stage. Depends on tcfr_pkg, tcfr_if.
module tcfr_back import tcfr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          pop,
   tcfr_rsp_if.source    rsp
);

   logic               busy_ff, busy_in;
   logic [3:0]         step_ff, step_in;
   cmd_type            cmd_ff, cmd_in;
   logic [7:0]         chk_ff, chk_in;

   logic               out_valid_ff, out_valid_in;
   rsp_kind_type       kind_ff, kind_in;
   logic [7:0]         ack_ff, ack_in;
   logic               set_ff, set_in;
   logic [3:0]         index_ff, index_in;
   logic signed [15:0] value_ff, value_in;
   logic               last_ff, last_in;

   logic               load_out, beat_last;
   logic [2:0]         ack_pos;

   always_comb begin
      load_out  = !out_valid_ff || rsp.ready;
      pop       = !busy_ff && cmd_valid;
      ack_pos   = 3'(step_ff - ACK_FIRST_STEP);
      beat_last = (cmd_ff.kind == CMD_READBACK) || (step_ff == LAST_STEP);

      busy_in      = busy_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      chk_in       = chk_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      ack_in       = ack_ff;
      set_in       = set_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      last_in      = last_ff;

      if (pop) begin
         busy_in = 1'b1;
         cmd_in  = cmd;
         chk_in  = ack_check(cmd.fn, cmd.sum);
         step_in = (cmd.kind == CMD_ACK) ? ACK_FIRST_STEP : 4'd0;
      end

      if (load_out) begin
         out_valid_in = busy_ff;
         kind_in      = KIND_ACK;
         ack_in       = '0;
         set_in       = 1'b0;
         index_in     = '0;
         value_in     = '0;
         last_in      = beat_last;
         if (cmd_ff.kind == CMD_READBACK) begin
            kind_in = KIND_READBACK;
         end else if (step_ff < ACK_FIRST_STEP) begin
            kind_in  = KIND_GAIN;
            set_in   = cmd_ff.fn[0];
            index_in = step_ff;
            value_in = cmd_ff.gains[step_ff];
         end else begin
            unique case (ack_pos)
               3'd0, 3'd1: ack_in = HDR1_BYTE;
               3'd2:       ack_in = ACK_ID;
               3'd3:       ack_in = ACK_LEN_BYTE;
               3'd4:       ack_in = cmd_ff.fn;
               3'd5:       ack_in = cmd_ff.sum;
               default:    ack_in = chk_ff;
            endcase
         end
         if (busy_ff) begin
            step_in = step_ff + 4'd1;
            if (beat_last) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      chk_ff   <= chk_in;
      kind_ff  <= kind_in;
      ack_ff   <= ack_in;
      set_ff   <= set_in;
      index_ff <= index_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = kind_ff;
   assign rsp.ack_byte   = ack_ff;
   assign rsp.gain_set   = set_ff;
   assign rsp.gain_index = index_ff;
   assign rsp.gain_value = value_ff;
   assign rsp.last       = last_ff;

endmodule

### hw/rtl/telemetry_command_frame_receiver.sv
// Telemetry command frame receiver: byte-framed command parser with additive checksum.
// Depends on tcfr_pkg, tcfr_if, tcfr_front, tcfr_queue, tcfr_back.
//
// Usage:
//   req carries one received link byte per beat; rsp carries result beats
//   (acknowledge byte, gain update or readback request), last marking the
//   final beat caused by one frame.
//   The parser takes one byte every cycle while the command queue is not full.
//   A good frame is decided on its checksum byte; its command passes through
//   the queue and the sequencer's command register into the output register,
//   and the frame's beats then follow one per cycle while rsp.ready is high:
//   1 for a readback, 7 for an acknowledge, 16 for a gain frame.
//   The sequencer loads the next command only after the last beat of the current one.
//   A two-entry command queue separates parser and sequencer. When rsp stalls,
//   the output register holds its beat, the queue fills with finished frames
//   and req.ready drops only once the queue is full.
//   Reset clears the parser, the payload store, the queue and the output valid flag.
module telemetry_command_frame_receiver import tcfr_pkg::*; #(
   parameter int MAX_LENGTH   = 49,
   parameter int KEPT_PAYLOAD = 18
) (
   input  logic       clock,
   input  logic       reset,
   tcfr_req_if.sink   req,
   tcfr_rsp_if.source rsp
);

   logic    q_full, q_empty, q_pop, push, byte_accept;
   cmd_type push_cmd, pop_cmd;

   assign req.ready   = !q_full;
   assign byte_accept = req.valid && !q_full;

   tcfr_front #(
      .MAX_LENGTH   (MAX_LENGTH),
      .KEPT_PAYLOAD (KEPT_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req.rx_byte),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tcfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   tcfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (pop_cmd),
      .pop       (q_pop),
      .rsp       (rsp)
   );

endmodule

### hw/rtl/tcfr_checker.sv
// Port-level checks for the telemetry command frame receiver, bound to the top level.
// Depends on tcfr_pkg.
module tcfr_checker import tcfr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rsp_kind_type       rsp_kind,
   input logic [7:0]         rsp_ack_byte,
   input logic [3:0]         rsp_gain_index,
   input logic signed [15:0] rsp_gain_value,
   input logic               rsp_last
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_ack_byte) && $stable(rsp_gain_value)
                                  && $stable(rsp_last))
      else $error("result payload changed while stalled");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_GAIN |-> !rsp_last && rsp_gain_index <= 4'd8)
      else $error("gain beat out of sequence");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_READBACK |-> rsp_last)
      else $error("readback beat not final");

endmodule

bind telemetry_command_frame_receiver tcfr_checker u_tcfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_kind       (rsp.kind),
   .rsp_ack_byte   (rsp.ack_byte),
   .rsp_gain_index (rsp.gain_index),
   .rsp_gain_value (rsp.gain_value),
   .rsp_last       (rsp.last)
);

### test/tb.sv
// Testbench for telemetry_command_frame_receiver: sends link bytes as directed and random frames,
// predicts the result beats of each good frame and checks every rsp beat against them in order.
// Depends on tcfr_pkg, tcfr_if and the receiver RTL.
`timescale 1ns / 1ps

module tb import tcfr_pkg::*; ();

   localparam int HALF_PERIOD   = 5;
   localparam int MAX_LEN       = 49;
   localparam int KEPT          = 18;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 1000;

   localparam logic [0:17][7:0] EDGE_GAINS = {
      8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
      8'h01, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h55, 8'hAA, 8'hAA, 8'h55
   };

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_type;

   typedef struct packed {
      rsp_kind_type       kind;
      logic [7:0]         ack_byte;
      logic               gain_set;
      logic [3:0]         gain_index;
      logic signed [15:0] gain_value;
      logic               last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset;

   tcfr_req_if req_ch ();
   tcfr_rsp_if rsp_ch ();

   telemetry_command_frame_receiver #(
      .MAX_LENGTH   (MAX_LEN),
      .KEPT_PAYLOAD (KEPT)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #HALF_PERIOD clock = ~clock;

   // parser shadow state
   phase_type  parse_phase;
   logic [7:0] frame_fn;
   logic [7:0] running_sum;
   logic [5:0] bytes_left;
   logic [5:0] payload_count;
   logic [7:0] payload_store [0:KEPT-1];

   frame_result_type pending_results[$];
   logic [7:0]       frame_payload [0:63];

   int             errors;
   int             idle_cycles;
   int             rx_beats;
   int             gap_max;
   int             burst_left;
   int             stall_phase;
   stall_mode_type stall_mode;

   function automatic frame_result_type make_result(
      input rsp_kind_type kind, input logic [7:0] ack, input logic set,
      input logic [3:0] idx, input logic [15:0] value);
      frame_result_type r;
      r.kind       = kind;
      r.ack_byte   = ack;
      r.gain_set   = set;
      r.gain_index = idx;
      r.gain_value = value;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic string fmt_result(input frame_result_type r);
      return $sformatf("kind=%0d ack=%h set=%0d index=%0d value=%0d last=%0d",
                       r.kind, r.ack_byte, r.gain_set, r.gain_index, r.gain_value, r.last);
   endfunction

   function automatic void emit_frame_results();
      frame_result_type burst [0:15];
      logic [0:6][7:0]  ack_frame;
      logic [7:0]       chk;
      int               n;
      int               k;
      n = 0;
      if (frame_fn == FN_READBACK && payload_store[0] == READBACK_ARG) begin
         burst[n] = make_result(KIND_READBACK, 8'h00, 1'b0, 4'd0, 16'h0000);
         n++;
      end
      if (frame_fn == FN_RATE || frame_fn == FN_ANGLE) begin
         for (k = 0; k < GAIN_COUNT; k++) begin
            burst[n] = make_result(KIND_GAIN, 8'h00, frame_fn[0], k[3:0],
                                   {payload_store[2*k], payload_store[2*k+1]});
            n++;
         end
      end
      if (frame_fn >= FN_RATE && frame_fn <= FN_ACK_LAST) begin
         chk = HDR1_BYTE + HDR1_BYTE + ACK_ID + ACK_LEN_BYTE + frame_fn + running_sum;
         ack_frame = {HDR1_BYTE, HDR1_BYTE, ACK_ID, ACK_LEN_BYTE, frame_fn, running_sum, chk};
         for (k = 0; k < 7; k++) begin
            burst[n] = make_result(KIND_ACK, ack_frame[k], 1'b0, 4'd0, 16'h0000);
            n++;
         end
      end
      if (n > 0)
         burst[n-1].last = 1'b1;
      for (k = 0; k < n; k++)
         pending_results.push_back(burst[k]);
   endfunction

   function automatic void parse_rx_byte(input logic [7:0] b);
      if (parse_phase == PH_IDLE && b == HDR1_BYTE) begin
         parse_phase = PH_HDR2;
         running_sum = b;
      end else if (parse_phase == PH_HDR2 && b == HDR2_BYTE) begin
         parse_phase = PH_FUNC;
         running_sum = running_sum + b;
      end else if (parse_phase == PH_FUNC && b < FUNC_LIMIT) begin
         parse_phase = PH_LEN;
         frame_fn    = b;
         running_sum = running_sum + b;
      end else if (parse_phase == PH_LEN && b <= MAX_LEN) begin
         parse_phase   = PH_DATA;
         bytes_left    = b[5:0];
         payload_count = 6'd0;
         running_sum   = running_sum + b;
      end else if (parse_phase == PH_DATA && bytes_left != 6'd0) begin
         if (payload_count < KEPT)
            payload_store[payload_count] = b;
         payload_count = payload_count + 6'd1;
         bytes_left    = bytes_left - 6'd1;
         running_sum   = running_sum + b;
         if (bytes_left == 6'd0)
            parse_phase = PH_CHECK;
      end else if (parse_phase == PH_CHECK) begin
         parse_phase = PH_IDLE;
         if (b == running_sum)
            emit_frame_results();
      end else begin
         parse_phase = PH_IDLE;
      end
   endfunction

   // check rsp beats, then advance the shadow parser on accepted bytes
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind       = rsp_ch.kind;
            got.ack_byte   = rsp_ch.ack_byte;
            got.gain_set   = rsp_ch.gain_set;
            got.gain_index = rsp_ch.gain_index;
            got.gain_value = rsp_ch.gain_value;
            got.last       = rsp_ch.last;
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat: expected none, actual %s",
                        $time, fmt_result(got));
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch: expected %s", $time, fmt_result(want));
                  $display("%0t:           actual   %s", $time, fmt_result(got));
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            parse_rx_byte(req_ch.rx_byte);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         STALL_NONE: begin
            rsp_ch.ready <= 1'b1;
         end
         STALL_RANDOM: begin
            rsp_ch.ready <= ($urandom_range(0, 99) < 70);
         end
         STALL_PATTERN: begin
            rsp_ch.ready <= (stall_phase % 32 < 22) && (stall_phase % 5 != 3);
         end
         default: begin
            rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      if (gap_max > 0 && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      rx_beats++;
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] fn, input logic [7:0] len, input bit bad_sum);
      logic [7:0] sum;
      int         i;
      sum = HDR1_BYTE + HDR2_BYTE + fn + len;
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(fn);
      send_byte(len);
      for (i = 0; i < len; i++) begin
         sum = sum + frame_payload[i];
         send_byte(frame_payload[i]);
      end
      send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic fill_payload();
      int i;
      for (i = 0; i < 64; i++)
         frame_payload[i] = 8'($urandom);
   endtask

   task automatic test_header_faults();
      gap_max = 0;
      stall_mode <= STALL_NONE;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR2_BYTE);
      // second header byte 0xAA is dropped, not taken as a new start
      send_byte(HDR1_BYTE);
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(HDR1_BYTE);
      send_byte(8'h55);
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(FUNC_LIMIT);
      send_byte(HDR1_BYTE);
      send_byte(HDR2_BYTE);
      send_byte(FN_RATE);
      send_byte(8'(MAX_LEN + 1));
      // zero length: next byte aborts
      send_frame(FN_ACK_LAST, 8'd0, 1'b0);
      frame_payload[0] = 8'h00;
      send_frame(8'h13, 8'd1, 1'b0);
      drain_results();
   endtask

   task automatic test_gain_frames();
      int i;
      gap_max = 3;
      stall_mode <= STALL_RANDOM;
      for (i = 0; i < GAIN_BYTES; i++)
         frame_payload[i] = EDGE_GAINS[i];
      send_frame(FN_RATE, 8'(GAIN_BYTES), 1'b0);
      // short frame: upper gains come from the stale store
      frame_payload[0] = 8'h12;
      frame_payload[1] = 8'h34;
      send_frame(FN_ANGLE, 8'd2, 1'b0);
      fill_payload();
      frame_payload[20] = HDR1_BYTE;
      frame_payload[21] = HDR2_BYTE;
      send_frame(FN_RATE, 8'(MAX_LEN), 1'b0);
      fill_payload();
      send_frame(FN_ANGLE, 8'(GAIN_BYTES), 1'b1);
      send_frame(FN_ANGLE, 8'd19, 1'b0);
      drain_results();
   endtask

   task automatic test_ack_and_readback();
      gap_max = 0;
      stall_mode <= STALL_PATTERN;
      fill_payload();
      frame_payload[0] = READBACK_ARG;
      send_frame(FN_READBACK, 8'd1, 1'b0);
      send_frame(FN_READBACK, 8'd3, 1'b1);
      frame_payload[0] = 8'h00;
      send_frame(FN_READBACK, 8'd3, 1'b0);
      send_frame(8'h0F, 8'd1, 1'b0);
      send_frame(8'h12, 8'd2, 1'b0);
      send_frame(8'h14, 8'd5, 1'b0);
      send_frame(FN_ACK_LAST, 8'd1, 1'b0);
      send_frame(8'h16, 8'd1, 1'b0);
      send_frame(FUNC_LIMIT - 8'd1, 8'd4, 1'b0);
      send_frame(8'h00, 8'd1, 1'b0);
      drain_results();
   endtask

   task automatic test_random_frames(input int byte_budget, input int gaps,
                                     input stall_mode_type mode);
      int         first_beat;
      int         pick;
      logic [7:0] fn;
      logic [7:0] len;
      gap_max = gaps;
      stall_mode <= mode;
      first_beat = rx_beats;
      while (rx_beats - first_beat < byte_budget) begin
         pick = $urandom_range(0, 99);
         fill_payload();
         fn  = 8'($urandom_range(0, FUNC_LIMIT - 1));
         len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(KEPT + 1, MAX_LEN))
                                           : 8'($urandom_range(0, 12));
         if (pick < 30) begin
            fn = $urandom_range(0, 1) ? FN_ANGLE : FN_RATE;
            if ($urandom_range(0, 2) != 0)
               len = 8'(GAIN_BYTES);
         end else if (pick < 50) begin
            fn = 8'($urandom_range(FN_ANGLE + 1, FN_ACK_LAST));
         end else if (pick < 62) begin
            fn = FN_READBACK;
            if ($urandom_range(0, 3) != 0)
               frame_payload[0] = READBACK_ARG;
            if (len == 8'd0 && $urandom_range(0, 3) != 0)
               len = 8'd1;
         end else if (pick >= 74 && pick < 82) begin
            fn  = 8'($urandom);
            len = 8'($urandom_range(0, 63));
         end
         if (pick < 82) begin
            send_frame(fn, len, $urandom_range(0, 11) == 0);
         end else begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 2) == 0) ? HDR1_BYTE : 8'($urandom));
         end
      end
      drain_results();
   endtask

   initial begin
      int i;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      stall_mode     = STALL_NONE;
      stall_phase    = 0;
      gap_max        = 0;
      burst_left     = 0;
      rx_beats       = 0;
      errors         = 0;
      idle_cycles    = 0;
      parse_phase    = PH_IDLE;
      frame_fn       = 8'h00;
      running_sum    = 8'h00;
      bytes_left     = 6'd0;
      payload_count  = 6'd0;
      for (i = 0; i < KEPT; i++)
         payload_store[i] = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_faults();
      test_gain_frames();
      test_ack_and_readback();
      test_random_frames(36, 0, STALL_NONE);
      test_random_frames(36, 6, STALL_RANDOM);
      test_random_frames(36, 2, STALL_HEAVY);

      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tcfr_pkg.sv
hw/rtl/tcfr_if.sv
hw/rtl/tcfr_front.sv
hw/rtl/tcfr_queue.sv
hw/rtl/tcfr_back.sv
hw/rtl/telemetry_command_frame_receiver.sv
hw/rtl/tcfr_checker.sv
test/tb.sv
